// File: rtl/core/top_k_score_select_core_assert.svh
// Assertion macros for the top-k score select core.
`ifndef TOP_K_SCORE_SELECT_CORE_ASSERT_SVH
`define TOP_K_SCORE_SELECT_CORE_ASSERT_SVH

// same-cycle implication
`define TKSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("top-k score select core check failed");

// next-cycle implication
`define TKSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("top-k score select core check failed");

`endif

// File: rtl/core/tkss_pkg.sv
// Package: widths, constants, slot type and float ordering helpers.
`default_nettype none
package tkss_pkg;

   localparam int SCORE_W       = 32;
   localparam int CLASS_W       = 16;
   localparam int RANK_W        = 3;
   localparam int DEF_TOP_K     = 5;
   localparam int DEF_MAX_ELEMS = 65536;
   localparam int RSP_DATA_W    = 56;

   localparam logic [SCORE_W-1:0] NEG_FLT_MAX_BITS = 32'hFF7F_FFFF;
   localparam logic [CLASS_W-1:0] EMPTY_CLASS      = 16'hFFFF;
   localparam logic [SCORE_W-1:0] KEY_FLOOR        = 32'h0080_0000;

   typedef struct packed {
      logic               filled;
      logic [SCORE_W-1:0] score;
      logic [CLASS_W-1:0] class_id;
   } tkss_slot_type;

   // unsigned key with the same order as the float, signed zeros folded
   function automatic logic [SCORE_W-1:0] order_key(input logic [SCORE_W-1:0] b);
      logic [SCORE_W-1:0] v;
      v = (b[SCORE_W-2:0] == '0) ? '0 : b;
      return v[SCORE_W-1] ? ~v : {1'b1, v[SCORE_W-2:0]};
   endfunction

   function automatic logic is_nan(input logic [SCORE_W-1:0] b);
      return b[SCORE_W-2:0] > 31'h7F80_0000;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/top_k_score_select_core.sv
// Top level of the top-k score select core.
`default_nettype none
// Takes one float32 score word per cycle; a word's position in its set is
// its class index. Scores greater than -FLT_MAX (never NaN, +0 == -0) are
// kept in a TOP_K-deep table sorted descending, ties to the earlier index.
// The tlast word closes the set and clears the table: min(count, TOP_K)
// result words follow, one per cycle while the result side accepts, rank 0
// first. The score path runs at one word per cycle; a tlast word is held at
// the input register while the previous run is still draining, and the
// result buffer reloads on the edge that takes the previous run's final
// word. So a set stalls the input only when the run before it has more
// result words than the set has scores, or when the result side holds off.
// Indexes saturate at MAX_ELEMS.
`include "top_k_score_select_core_assert.svh"
module top_k_score_select_core
   import tkss_pkg::*;
#(
   parameter int TOP_K     = DEF_TOP_K,
   parameter int MAX_ELEMS = DEF_MAX_ELEMS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [SCORE_W-1:0]    req_tdata,   // [31:0] score_bits
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [2:0] rank, [34:3] best_score_bits,
                                                   // [50:35] class_id, [55:51] zero
   output logic                       rsp_tuser,   // [0] found
   output logic                       rsp_tlast
);

   localparam int NW = $clog2(TOP_K + 1);

   logic               in_valid, in_last, in_ready;
   logic [SCORE_W-1:0] in_score;
   logic               load_ok, load_valid;
   tkss_slot_type      load_slots [TOP_K];
   logic [NW-1:0]      load_count;

   tkss_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .in_valid   (in_valid),
      .in_score   (in_score),
      .in_last    (in_last),
      .in_ready   (in_ready)
   );

   tkss_table #(
      .TOP_K     (TOP_K),
      .MAX_ELEMS (MAX_ELEMS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid),
      .in_score   (in_score),
      .in_last    (in_last),
      .in_ready   (in_ready),
      .load_ok    (load_ok),
      .load_valid (load_valid),
      .load_slots (load_slots),
      .load_count (load_count)
   );

   tkss_emit #(
      .TOP_K (TOP_K)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load_valid (load_valid),
      .load_slots (load_slots),
      .load_count (load_count),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `TKSS_ASSERT_NOW(a_empty_word, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata[34:3] == NEG_FLT_MAX_BITS && rsp_tdata[50:35] == EMPTY_CLASS)
   `TKSS_ASSERT_NEXT(a_run_restart, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
      !rsp_tvalid || rsp_tdata[2:0] == '0)
   `TKSS_ASSERT_NEXT(a_rank_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast,
      rsp_tvalid && rsp_tdata[2:0] == $past(rsp_tdata[2:0]) + 3'd1)
   `TKSS_ASSERT_NEXT(a_empty_tail, clock, reset,
      rsp_tvalid && rsp_tready && !rsp_tlast && !rsp_tuser, !rsp_tuser)

endmodule
`default_nettype wire

// File: rtl/core/tkss_in_reg.sv
// Input register stage for incoming score words.
`default_nettype none
module tkss_in_reg
   import tkss_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [SCORE_W-1:0] req_tdata,
   input  wire logic               req_tlast,
   output logic                    in_valid,
   output logic [SCORE_W-1:0]      in_score,
   output logic                    in_last,
   input  wire logic               in_ready
);

   logic               valid_ff, valid_in;
   logic [SCORE_W-1:0] score_ff;
   logic               last_ff;
   logic               req_fire;

   assign req_tready = !valid_ff || in_ready;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (req_fire) begin
         valid_in = 1'b1;
      end else if (in_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         score_ff <= req_tdata;
         last_ff  <= req_tlast;
      end
   end

   assign in_valid = valid_ff;
   assign in_score = score_ff;
   assign in_last  = last_ff;

endmodule
`default_nettype wire

// File: rtl/core/tkss_table.sv
// Sorted top-k table with insertion update and item counter.
`default_nettype none
module tkss_table
   import tkss_pkg::*;
#(
   parameter int TOP_K     = DEF_TOP_K,
   parameter int MAX_ELEMS = DEF_MAX_ELEMS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [SCORE_W-1:0] in_score,
   input  wire logic               in_last,
   output logic                    in_ready,
   input  wire logic               load_ok,
   output logic                    load_valid,
   output tkss_slot_type           load_slots [TOP_K],
   output logic [$clog2(TOP_K+1)-1:0] load_count
);

   localparam int CNT_W = $clog2(MAX_ELEMS + 1);
   localparam int NW    = $clog2(TOP_K + 1);

   tkss_slot_type      slot_ff [TOP_K];
   tkss_slot_type      slot_in [TOP_K];
   tkss_slot_type      upd     [TOP_K];
   tkss_slot_type      new_slot;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, cnt_next;
   logic [CNT_W+CLASS_W-1:0] cnt_ext;
   logic [CNT_W+NW-1:0] cnt_wide;
   logic [SCORE_W-1:0] key;
   logic [TOP_K-1:0]   ge;
   logic               take, qualify, fire;

   assign in_ready = !in_last || load_ok;
   assign fire     = in_valid && in_ready;

   assign take     = cnt_ff < CNT_W'(MAX_ELEMS);
   assign cnt_next = take ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign key      = order_key(in_score);
   assign qualify  = take && !is_nan(in_score) && (key > KEY_FLOOR);
   assign cnt_ext  = {{CLASS_W{1'b0}}, cnt_ff};

   always_comb begin
      new_slot.filled   = 1'b1;
      new_slot.score    = in_score;
      new_slot.class_id = cnt_ext[CLASS_W-1:0];
   end

   for (genvar i = 0; i < TOP_K; i++) begin : g_slot
      assign ge[i] = slot_ff[i].filled && (order_key(slot_ff[i].score) >= key);
      if (i == 0) begin : g_head
         assign upd[i] = (!qualify || ge[i]) ? slot_ff[i] : new_slot;
      end else begin : g_body
         assign upd[i] = (!qualify || ge[i]) ? slot_ff[i] :
                         (ge[i-1] ? new_slot : slot_ff[i-1]);
      end
   end

   always_comb begin
      for (int i = 0; i < TOP_K; i++) begin
         slot_in[i] = slot_ff[i];
         if (fire) begin
            slot_in[i] = upd[i];
            if (in_last) begin
               slot_in[i].filled = 1'b0;
            end
         end
      end
      cnt_in = cnt_ff;
      if (fire) begin
         cnt_in = in_last ? '0 : cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         for (int i = 0; i < TOP_K; i++) begin
            slot_ff[i].filled <= 1'b0;
         end
      end else begin
         cnt_ff <= cnt_in;
         for (int i = 0; i < TOP_K; i++) begin
            slot_ff[i].filled <= slot_in[i].filled;
         end
      end
      for (int i = 0; i < TOP_K; i++) begin
         slot_ff[i].score    <= slot_in[i].score;
         slot_ff[i].class_id <= slot_in[i].class_id;
      end
   end

   assign cnt_wide   = {{NW{1'b0}}, cnt_next};
   assign load_valid = fire && in_last;
   assign load_count = (cnt_wide >= (CNT_W+NW)'(TOP_K)) ? NW'(TOP_K) : cnt_wide[NW-1:0];
   assign load_slots = upd;

endmodule
`default_nettype wire

// File: rtl/core/tkss_emit.sv
// Result buffer that drains one ranked result word per cycle while rsp_tready is high.
`default_nettype none
module tkss_emit
   import tkss_pkg::*;
#(
   parameter int TOP_K = DEF_TOP_K
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load_valid,
   input  wire tkss_slot_type         load_slots [TOP_K],
   input  wire logic [$clog2(TOP_K+1)-1:0] load_count,
   output logic                       load_ok,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tuser,
   output logic                       rsp_tlast
);

   localparam int NW = $clog2(TOP_K + 1);

   tkss_slot_type     buf_ff [TOP_K];
   tkss_slot_type     buf_in [TOP_K];
   logic [NW-1:0]     rem_ff, rem_in;
   logic [RANK_W-1:0] rank_ff, rank_in;
   logic              busy, fire;
   logic [SCORE_W-1:0] out_score;
   logic [CLASS_W-1:0] out_class;

   assign busy    = rem_ff != '0;
   assign fire    = busy && rsp_tready;
   // reload when idle or on the edge that takes the final word of the current run
   assign load_ok = !busy || (rem_ff == NW'(1) && rsp_tready);

   always_comb begin
      rem_in  = rem_ff;
      rank_in = rank_ff;
      for (int i = 0; i < TOP_K; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (load_valid) begin
         rem_in  = load_count;
         rank_in = '0;
         for (int i = 0; i < TOP_K; i++) begin
            buf_in[i] = load_slots[i];
         end
      end else if (fire) begin
         rem_in  = rem_ff - NW'(1);
         rank_in = rank_ff + RANK_W'(1);
         for (int i = 0; i < TOP_K - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         buf_in[TOP_K-1].filled = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff  <= '0;
         rank_ff <= '0;
      end else begin
         rem_ff  <= rem_in;
         rank_ff <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TOP_K; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

   assign out_score  = buf_ff[0].filled ? buf_ff[0].score : NEG_FLT_MAX_BITS;
   assign out_class  = buf_ff[0].filled ? buf_ff[0].class_id : EMPTY_CLASS;
   assign rsp_tvalid = busy;
   assign rsp_tlast  = rem_ff == NW'(1);
   assign rsp_tuser  = buf_ff[0].filled;
   assign rsp_tdata  = {(RSP_DATA_W-RANK_W-SCORE_W-CLASS_W)'(0), out_class, out_score, rank_ff};

endmodule
`default_nettype wire
